### rtl/core/dst_pkg.sv
package dst_pkg;

  // Request codes carried on the cmd field.
  typedef enum logic [2:0] {
    CMD_CLEAR       = 3'd0,
    CMD_LOWEST_FREE = 3'd1,
    CMD_FREE        = 3'd2,
    CMD_GET         = 3'd3,
    CMD_INSTALL     = 3'd4,
    CMD_DUP         = 3'd5,
    CMD_DUP2        = 3'd6,
    CMD_CLOSE_RANGE = 3'd7
  } cmd_t;

  // Result kinds.
  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  // One result item as held in the output register.
  typedef struct packed {
    logic        kind;
    logic [15:0] handle_out;
    logic [7:0]  answer;
    logic        failed;
    logic        ref_increment;
    logic        slot_valid;
    logic [4:0]  open_count;
    logic        last;
  } res_t;

  // Commands from the sequencer to the slot cursor.
  typedef struct packed {
    logic load;
    logic step;
  } cur_ctl_t;

endpackage

### rtl/core/dst_req_if.sv
interface dst_req_if;
  logic             valid;
  logic             ready;
  dst_pkg::cmd_t    cmd;
  logic [7:0]       fd_a;
  logic [7:0]       fd_b;
  logic [15:0]      handle_in;

  modport source (output valid, output cmd, output fd_a, output fd_b, output handle_in,
                  input ready);
  modport sink (input valid, input cmd, input fd_a, input fd_b, input handle_in,
                output ready);
endinterface

### rtl/core/dst_res_if.sv
interface dst_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] handle_out;
  logic [7:0]  answer;
  logic        failed;
  logic        ref_increment;
  logic        slot_valid;
  logic [4:0]  open_count;
  logic        last;

  modport source (output valid, output kind, output handle_out, output answer,
                  output failed, output ref_increment, output slot_valid,
                  output open_count, output last, input ready);
  modport sink (input valid, input kind, input handle_out, input answer,
                input failed, input ref_increment, input slot_valid,
                input open_count, input last, output ready);
endinterface

### rtl/core/dst_ram.sv
module dst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/dst_cursor.sv
module dst_cursor #(
  parameter int IW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dst_pkg::cur_ctl_t  ctl,
  input  logic [IW-1:0]      load_val,
  input  logic [IW-1:0]      limit,
  output logic [IW-1:0]      idx,
  output logic               at_end
);
  import dst_pkg::*;

  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;

  // Shared slot index: loaded to start a walk, steps one slot a cycle on step.
  always_comb begin
    idx_nxt = idx_r;
    if (ctl.load) begin
      idx_nxt = load_val;
    end else if (ctl.step) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign idx    = idx_r;
  assign at_end = (idx_r == limit);

endmodule

### rtl/core/descriptor_slot_table.sv
// Channel   Dir  Payload                                           Transfer
// in_req    in   cmd, fd_a, fd_b, handle_in                        valid & ready
// out_res   out  kind, handle_out, answer, failed, ref_increment,  valid & ready
//                slot_valid, open_count, last
//
// A request is transferred, then decoded. Clear, get, install and a free of an
// empty slot answer from decode; a free that closes a slot sends its notice and
// then the final answer, and dup2 may close an occupied target before filling it.
// Lowest free and dup walk the slot cursor from slot 0 one slot a cycle up to the
// first free one, checking at most SLOTS slots. Close range walks fd_a..fd_b,
// reading each occupied slot's handle for its notice, then sends the final answer.
// Reset empties the table at once; the handle memory needs no clearing pass.
// A stalled result register holds the sequencer; a new request is taken as soon
// as the final answer of the previous one sits in the result register.
module descriptor_slot_table #(
  parameter int SLOTS       = 16,
  parameter int HANDLE_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  dst_req_if.sink    in_req,
  dst_res_if.source  out_res
);
  import dst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int HB = HANDLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_D2_CLOSE,
    S_D2_FILL,
    S_RNG_CHK,
    S_RNG_EMIT,
    S_FINAL
  } state_t;

  // Width adapters between internal widths and the fixed port fields.
  function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
    logic [CW+4:0] t;
    t = {5'b0, c};
    return t[4:0];
  endfunction

  function automatic logic [7:0] idx8(input logic [IW-1:0] i);
    logic [IW+7:0] t;
    t = {8'b0, i};
    return t[7:0];
  endfunction

  function automatic logic [15:0] h16(input logic [HB-1:0] h);
    logic [HB+15:0] t;
    t = {16'b0, h};
    return t[15:0];
  endfunction

  function automatic logic [HB-1:0] hin_fit(input logic [15:0] h);
    logic [HB+15:0] t;
    t = {{HB{1'b0}}, h};
    return t[HB-1:0];
  endfunction

  function automatic res_t fin(input logic [15:0] h, input logic [7:0] ans,
                               input logic fl, input logic rf, input logic sv,
                               input logic [4:0] oc);
    res_t r;
    r.kind          = KIND_FINAL;
    r.handle_out    = h;
    r.answer        = ans;
    r.failed        = fl;
    r.ref_increment = rf;
    r.slot_valid    = sv;
    r.open_count    = oc;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic res_t notice(input logic [15:0] h, input logic [7:0] slot,
                                  input logic [4:0] oc);
    res_t r;
    r               = '0;
    r.kind          = KIND_NOTICE;
    r.handle_out    = h;
    r.answer        = slot;
    r.open_count    = oc;
    return r;
  endfunction

  state_t         state_r, state_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [HB-1:0]  hold_r, hold_nxt;
  logic [7:0]     tally_r, tally_nxt;
  cmd_t           cmd_r;
  logic [7:0]     a_r, b_r;
  logic           a_ok_r, b_ok_r;
  logic [HB-1:0]  h_r;
  logic           out_valid_r;
  res_t           res_r, res_nxt;
  logic           emit;
  logic           can_emit;
  logic           in_xfer;
  logic           in_a_ok;

  logic [IW-1:0]  a_idx, b_idx, in_a_idx;
  logic [CW-1:0]  cnt_inc, cnt_dec;

  cur_ctl_t       cur_ctl;
  logic [IW-1:0]  cur_load;
  logic [IW-1:0]  cur_limit;
  logic [IW-1:0]  cur_idx;
  logic           cur_end;

  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic [HB-1:0]  wr_data, rd_data;

  assign a_idx    = a_r[IW-1:0];
  assign b_idx    = b_r[IW-1:0];
  assign in_a_idx = in_req.fd_a[IW-1:0];
  assign in_a_ok  = ({1'b0, in_req.fd_a} < 9'(SLOTS));
  assign cnt_inc  = cnt_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_xfer      = in_req.valid && in_req.ready;
  assign can_emit     = !out_valid_r || out_res.ready;

  // The cursor stops at the last slot for searches and at fd_b for a range.
  assign cur_limit = (cmd_r == CMD_CLOSE_RANGE) ? b_idx : IW'(SLOTS - 1);

  dst_cursor #(.IW(IW)) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cur_ctl),
    .load_val (cur_load),
    .limit    (cur_limit),
    .idx      (cur_idx),
    .at_end   (cur_end)
  );

  dst_ram #(.WIDTH(HB), .DEPTH(SLOTS)) u_handles (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: every table update happens in the cycle its result is loaded.
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    cnt_nxt   = cnt_r;
    hold_nxt  = hold_r;
    tally_nxt = tally_r;
    emit      = 1'b0;
    res_nxt   = '0;
    cur_ctl   = '0;
    cur_load  = '0;
    rd_en     = 1'b0;
    rd_addr   = a_idx;
    wr_en     = 1'b0;
    wr_addr   = a_idx;
    wr_data   = hold_r;

    case (state_r)
      S_IDLE: begin
        // Start the handle read for fd_a with the transfer itself.
        if (in_xfer) begin
          rd_en     = in_a_ok;
          rd_addr   = in_a_idx;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (can_emit) begin
          case (cmd_r)
            CMD_CLEAR: begin
              used_nxt  = '0;
              cnt_nxt   = '0;
              emit      = 1'b1;
              res_nxt   = fin('0, '0, 1'b0, 1'b0, 1'b0, '0);
              state_nxt = S_IDLE;
            end
            CMD_LOWEST_FREE: begin
              cur_ctl.load = 1'b1;
              state_nxt    = S_SCAN;
            end
            CMD_FREE: begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (!a_ok_r) begin
                res_nxt = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
              end else if (used_r[a_idx]) begin
                used_nxt[a_idx] = 1'b0;
                cnt_nxt         = cnt_dec;
                tally_nxt       = a_r;
                res_nxt         = notice(h16(rd_data), a_r, cnt5(cnt_dec));
                state_nxt       = S_FINAL;
              end else begin
                res_nxt = fin('0, a_r, 1'b0, 1'b0, 1'b0, cnt5(cnt_r));
              end
            end
            CMD_GET: begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (!a_ok_r) begin
                res_nxt = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
              end else if (used_r[a_idx]) begin
                res_nxt = fin(h16(rd_data), a_r, 1'b0, 1'b0, 1'b1, cnt5(cnt_r));
              end else begin
                res_nxt = fin('0, a_r, 1'b0, 1'b0, 1'b0, cnt5(cnt_r));
              end
            end
            CMD_INSTALL: begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (!a_ok_r || h_r == '0) begin
                res_nxt = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
              end else begin
                // Replacing an occupied slot keeps the count.
                wr_en           = 1'b1;
                wr_addr         = a_idx;
                wr_data         = h_r;
                used_nxt[a_idx] = 1'b1;
                cnt_nxt         = used_r[a_idx] ? cnt_r : cnt_inc;
                res_nxt = fin('0, a_r, 1'b0, 1'b0, 1'b0, cnt5(cnt_nxt));
              end
            end
            CMD_DUP: begin
              if (!a_ok_r || !used_r[a_idx]) begin
                emit      = 1'b1;
                res_nxt   = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
                state_nxt = S_IDLE;
              end else begin
                hold_nxt     = rd_data;
                cur_ctl.load = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            CMD_DUP2: begin
              if (!a_ok_r || !b_ok_r || !used_r[a_idx]) begin
                emit      = 1'b1;
                res_nxt   = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
                state_nxt = S_IDLE;
              end else if (a_r == b_r) begin
                emit      = 1'b1;
                res_nxt   = fin(h16(rd_data), a_r, 1'b0, 1'b0, 1'b0, cnt5(cnt_r));
                state_nxt = S_IDLE;
              end else begin
                hold_nxt = rd_data;
                if (used_r[b_idx]) begin
                  // Fetch the target's handle for its close notice.
                  rd_en     = 1'b1;
                  rd_addr   = b_idx;
                  state_nxt = S_D2_CLOSE;
                end else begin
                  state_nxt = S_D2_FILL;
                end
              end
            end
            CMD_CLOSE_RANGE: begin
              if (!a_ok_r || !b_ok_r || (a_r > b_r)) begin
                emit      = 1'b1;
                res_nxt   = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
                state_nxt = S_IDLE;
              end else begin
                tally_nxt    = '0;
                cur_ctl.load = 1'b1;
                cur_load     = a_idx;
                state_nxt    = S_RNG_CHK;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Walk toward the lowest free slot; dup copies the held handle into it.
        if (!used_r[cur_idx]) begin
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (cmd_r == CMD_DUP) begin
              wr_en             = 1'b1;
              wr_addr           = cur_idx;
              used_nxt[cur_idx] = 1'b1;
              cnt_nxt           = cnt_inc;
              res_nxt = fin(h16(hold_r), idx8(cur_idx), 1'b0, 1'b1, 1'b0, cnt5(cnt_inc));
            end else begin
              res_nxt = fin('0, idx8(cur_idx), 1'b0, 1'b0, 1'b0, cnt5(cnt_r));
            end
          end
        end else if (cur_end) begin
          if (can_emit) begin
            emit      = 1'b1;
            res_nxt   = fin('0, '0, 1'b1, 1'b0, 1'b0, cnt5(cnt_r));
            state_nxt = S_IDLE;
          end
        end else begin
          cur_ctl.step = 1'b1;
        end
      end

      S_D2_CLOSE: begin
        if (can_emit) begin
          emit            = 1'b1;
          used_nxt[b_idx] = 1'b0;
          cnt_nxt         = cnt_dec;
          res_nxt         = notice(h16(rd_data), b_r, cnt5(cnt_dec));
          state_nxt       = S_D2_FILL;
        end
      end

      S_D2_FILL: begin
        if (can_emit) begin
          emit            = 1'b1;
          wr_en           = 1'b1;
          wr_addr         = b_idx;
          used_nxt[b_idx] = 1'b1;
          cnt_nxt         = cnt_inc;
          res_nxt   = fin(h16(hold_r), b_r, 1'b0, 1'b1, 1'b0, cnt5(cnt_inc));
          state_nxt = S_IDLE;
        end
      end

      S_RNG_CHK: begin
        // Occupied slots need a handle read before their notice.
        if (used_r[cur_idx]) begin
          rd_en     = 1'b1;
          rd_addr   = cur_idx;
          state_nxt = S_RNG_EMIT;
        end else if (cur_end) begin
          state_nxt = S_FINAL;
        end else begin
          cur_ctl.step = 1'b1;
        end
      end

      S_RNG_EMIT: begin
        if (can_emit) begin
          emit              = 1'b1;
          used_nxt[cur_idx] = 1'b0;
          cnt_nxt           = cnt_dec;
          tally_nxt         = tally_r + 1'b1;
          res_nxt = notice(h16(rd_data), idx8(cur_idx), cnt5(cnt_dec));
          if (cur_end) begin
            state_nxt = S_FINAL;
          end else begin
            cur_ctl.step = 1'b1;
            state_nxt    = S_RNG_CHK;
          end
        end
      end

      S_FINAL: begin
        if (can_emit) begin
          emit      = 1'b1;
          res_nxt   = fin('0, tally_r, 1'b0, 1'b0, 1'b0, cnt5(cnt_r));
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, table valid bits, request capture and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    hold_r  <= hold_nxt;
    tally_r <= tally_nxt;
    if (emit) begin
      res_r <= res_nxt;
    end
    if (in_xfer) begin
      cmd_r  <= in_req.cmd;
      a_r    <= in_req.fd_a;
      b_r    <= in_req.fd_b;
      a_ok_r <= in_a_ok;
      b_ok_r <= ({1'b0, in_req.fd_b} < 9'(SLOTS));
      h_r    <= hin_fit(in_req.handle_in);
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.kind          = res_r.kind;
  assign out_res.handle_out    = res_r.handle_out;
  assign out_res.answer        = res_r.answer;
  assign out_res.failed        = res_r.failed;
  assign out_res.ref_increment = res_r.ref_increment;
  assign out_res.slot_valid    = res_r.slot_valid;
  assign out_res.open_count    = res_r.open_count;
  assign out_res.last          = res_r.last;

endmodule

### verif/descriptor_slot_table_tb.sv
module descriptor_slot_table_tb;
  import dst_pkg::*;

  localparam int TBL_SLOTS  = 16;
  localparam int HOLD_TICKS = 300;

  logic clk;
  logic rst_n;

  dst_req_if req_ch ();
  dst_res_if res_ch ();

  descriptor_slot_table #(
    .SLOTS       (TBL_SLOTS),
    .HANDLE_BITS (16)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  // Shadow copy of the descriptor table, updated at each accepted request.
  logic [TBL_SLOTS-1:0] slot_busy;
  logic [15:0]          slot_fh [TBL_SLOTS];
  int                   open_slots;

  // Results still owed by the block, oldest first.
  res_t expected_results [$];

  // Traffic shaping shared between the test flow, the receiver and the hold-off timer.
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   hold_req = 1'b0;
  logic rx_hold  = 1'b0;

  int fail_count   = 0;
  int reqs_sent    = 0;
  int results_seen = 0;
  int notices_seen = 0;
  int rejects_seen = 0;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(logic kind, logic [15:0] fh, int ans, logic rej,
                                      logic refi, logic sv);
    res_t r;
    r.kind          = kind;
    r.handle_out    = fh;
    r.answer        = ans[7:0];
    r.failed        = rej;
    r.ref_increment = refi;
    r.slot_valid    = sv;
    r.open_count    = open_slots[4:0];
    r.last          = (kind == KIND_FINAL);
    expected_results.push_back(r);
  endfunction

  function automatic void push_reject();
    push_result(KIND_FINAL, '0, 0, 1'b1, 1'b0, 1'b0);
  endfunction

  function automatic int lowest_free_slot();
    for (int s = 0; s < TBL_SLOTS; s++) begin
      if (!slot_busy[s]) return s;
    end
    return TBL_SLOTS;
  endfunction

  // Empties one slot; an occupied slot owes a close notice for its handle.
  function automatic bit release_slot(int s);
    if (!slot_busy[s]) return 1'b0;
    slot_busy[s] = 1'b0;
    open_slots--;
    push_result(KIND_NOTICE, slot_fh[s], s, 1'b0, 1'b0, 1'b0);
    return 1'b1;
  endfunction

  function automatic void table_predict(cmd_t c, logic [7:0] a, logic [7:0] b,
                                        logic [15:0] h);
    bit a_ok;
    bit b_ok;
    int slot;
    int closed;
    a_ok   = (a < TBL_SLOTS);
    b_ok   = (b < TBL_SLOTS);
    closed = 0;
    case (c)
      CMD_CLEAR: begin
        slot_busy  = '0;
        open_slots = 0;
        push_result(KIND_FINAL, '0, 0, 1'b0, 1'b0, 1'b0);
      end
      CMD_LOWEST_FREE: begin
        slot = lowest_free_slot();
        if (slot < TBL_SLOTS) push_result(KIND_FINAL, '0, slot, 1'b0, 1'b0, 1'b0);
        else push_reject();
      end
      CMD_FREE: begin
        if (!a_ok) begin
          push_reject();
        end else begin
          void'(release_slot(a));
          push_result(KIND_FINAL, '0, a, 1'b0, 1'b0, 1'b0);
        end
      end
      CMD_GET: begin
        if (!a_ok) push_reject();
        else if (slot_busy[a]) push_result(KIND_FINAL, slot_fh[a], a, 1'b0, 1'b0, 1'b1);
        else push_result(KIND_FINAL, '0, a, 1'b0, 1'b0, 1'b0);
      end
      CMD_INSTALL: begin
        if (!a_ok || h == '0) begin
          push_reject();
        end else begin
          // Replacing a live handle keeps the open count as it is.
          if (!slot_busy[a]) begin
            slot_busy[a] = 1'b1;
            open_slots++;
          end
          slot_fh[a] = h;
          push_result(KIND_FINAL, '0, a, 1'b0, 1'b0, 1'b0);
        end
      end
      CMD_DUP: begin
        slot = lowest_free_slot();
        if (!a_ok || !slot_busy[a] || slot >= TBL_SLOTS) begin
          push_reject();
        end else begin
          slot_fh[slot]   = slot_fh[a];
          slot_busy[slot] = 1'b1;
          open_slots++;
          push_result(KIND_FINAL, slot_fh[a], slot, 1'b0, 1'b1, 1'b0);
        end
      end
      CMD_DUP2: begin
        if (!a_ok || !b_ok || !slot_busy[a]) begin
          push_reject();
        end else if (a == b) begin
          push_result(KIND_FINAL, slot_fh[a], a, 1'b0, 1'b0, 1'b0);
        end else begin
          // An occupied target is closed before it takes the copy.
          void'(release_slot(b));
          slot_fh[b]   = slot_fh[a];
          slot_busy[b] = 1'b1;
          open_slots++;
          push_result(KIND_FINAL, slot_fh[a], b, 1'b0, 1'b1, 1'b0);
        end
      end
      CMD_CLOSE_RANGE: begin
        if (!a_ok || !b_ok || a > b) begin
          push_reject();
        end else begin
          for (int s = a; s <= b; s++) begin
            if (release_slot(s)) closed++;
          end
          push_result(KIND_FINAL, '0, closed, 1'b0, 1'b0, 1'b0);
        end
      end
      default: push_reject();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge where it transfers. Valid stays
  // high for the next request unless that one draws a gap.
  task automatic send_req(cmd_t c, logic [7:0] a, logic [7:0] b, logic [15:0] h);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= c;
    req_ch.fd_a      <= a;
    req_ch.fd_b      <= b;
    req_ch.handle_in <= h;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    table_predict(c, a, b, h);
    reqs_sent++;
  endtask

  // The sender goes quiet until every owed result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_fd();
    if ($urandom_range(0, 99) < 88) return 8'($urandom_range(0, TBL_SLOTS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_handle();
    if ($urandom_range(0, 99) < 5) return '0;
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  function automatic string res_text(res_t r);
    return $sformatf("kind=%0d handle=%h answer=%0d failed=%0d ref=%0d valid=%0d open=%0d last=%0d",
                     r.kind, r.handle_out, r.answer, r.failed, r.ref_increment,
                     r.slot_valid, r.open_count, r.last);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    res_t  got;
    res_t  want;
    string diff;
    got.kind          = res_ch.kind;
    got.handle_out    = res_ch.handle_out;
    got.answer        = res_ch.answer;
    got.failed        = res_ch.failed;
    got.ref_increment = res_ch.ref_increment;
    got.slot_valid    = res_ch.slot_valid;
    got.open_count    = res_ch.open_count;
    got.last          = res_ch.last;
    results_seen++;
    if (got.kind == KIND_NOTICE) notices_seen++;
    else if (got.failed === 1'b1) rejects_seen++;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result with nothing owed: %s", res_text(got)));
      return;
    end
    want = expected_results.pop_front();
    diff = "";
    if (got.kind !== want.kind) diff = {diff, " kind"};
    if (got.handle_out !== want.handle_out) diff = {diff, " handle_out"};
    if (got.answer !== want.answer) diff = {diff, " answer"};
    if (got.failed !== want.failed) diff = {diff, " failed"};
    if (got.ref_increment !== want.ref_increment) diff = {diff, " ref_increment"};
    if (got.slot_valid !== want.slot_valid) diff = {diff, " slot_valid"};
    if (got.open_count !== want.open_count) diff = {diff, " open_count"};
    if (got.last !== want.last) diff = {diff, " last"};
    if (diff != "") begin
      note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                             results_seen, diff, res_text(want), res_text(got)));
    end
  endtask

  // Receiver: a random stall before each transfer outside receive bursts, plus any long hold-off.
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0 || rx_hold) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready) && !rx_hold) @(posedge clk);
      if (res_ch.valid && res_ch.ready) check_result();
    end
  end

  // Counts out one long receiver hold-off each time the test flow asks for it.
  initial begin : hold_timer
    forever begin
      wait (hold_req);
      @(posedge clk);
      rx_hold <= 1'b1;
      repeat (HOLD_TICKS) @(posedge clk);
      rx_hold  <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Requests against the table as it comes out of reset.
  task automatic test_empty_table();
    send_req(CMD_GET, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_LOWEST_FREE, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_FREE, 8'd7, 8'd0, 16'h0000);
    send_req(CMD_CLOSE_RANGE, 8'd0, 8'(TBL_SLOTS - 1), 16'h0000);
    send_req(CMD_FREE, 8'(TBL_SLOTS), 8'd0, 16'h0000);
    drain_results();
  endtask

  // Install at both ends, null and out-of-range installs, replacement, gets.
  task automatic test_install_get();
    send_req(CMD_INSTALL, 8'd0, 8'd0, 16'hFFFF);
    send_req(CMD_INSTALL, 8'(TBL_SLOTS - 1), 8'hFF, 16'h0001);
    send_req(CMD_INSTALL, 8'd3, 8'd0, 16'h0000);
    send_req(CMD_INSTALL, 8'hFF, 8'd0, 16'h1234);
    send_req(CMD_INSTALL, 8'd0, 8'd0, 16'h8000);
    send_req(CMD_GET, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_GET, 8'(TBL_SLOTS - 1), 8'd0, 16'h0000);
    send_req(CMD_GET, 8'd200, 8'd0, 16'h0000);
    drain_results();
  endtask

  // Dup into the lowest free slot, dup2 onto occupied, equal and bad targets.
  task automatic test_dup_paths();
    send_req(CMD_DUP, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_DUP, 8'd4, 8'd0, 16'h0000);
    send_req(CMD_DUP2, 8'd0, 8'(TBL_SLOTS - 1), 16'h0000);
    send_req(CMD_DUP2, 8'd1, 8'd1, 16'h0000);
    send_req(CMD_DUP2, 8'd6, 8'd2, 16'h0000);
    send_req(CMD_DUP2, 8'd0, 8'(TBL_SLOTS), 16'h0000);
    send_req(CMD_DUP2, 8'd0, 8'd9, 16'h0000);
    send_req(CMD_DUP, 8'd170, 8'd0, 16'h0000);
    drain_results();
  endtask

  // Reversed and out-of-range ranges, a closing free, a full sweep, clear.
  task automatic test_close_and_clear();
    send_req(CMD_CLOSE_RANGE, 8'd9, 8'd3, 16'h0000);
    send_req(CMD_CLOSE_RANGE, 8'd0, 8'hFF, 16'h0000);
    send_req(CMD_FREE, 8'd1, 8'd0, 16'h0000);
    send_req(CMD_CLOSE_RANGE, 8'd0, 8'(TBL_SLOTS - 1), 16'h0000);
    send_req(CMD_INSTALL, 8'd2, 8'd0, 16'hA5A5);
    send_req(CMD_CLEAR, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_GET, 8'd2, 8'd0, 16'h0000);
    drain_results();
  endtask

  // Fills every slot back to back while the receiver holds off, then runs the
  // full-table rejections and a replacing install, and closes the whole table at once.
  task automatic test_full_table_backpressure();
    hold_req = 1'b1;
    tx_burst = 1'b1;
    for (int s = 0; s < TBL_SLOTS; s++) begin
      send_req(CMD_INSTALL, 8'(s), 8'd0, 16'($urandom_range(1, 16'hFFFF)));
    end
    send_req(CMD_LOWEST_FREE, 8'd0, 8'd0, 16'h0000);
    send_req(CMD_DUP, 8'd3, 8'd0, 16'h0000);
    send_req(CMD_INSTALL, 8'd7, 8'd0, 16'h5A5A);
    send_req(CMD_CLOSE_RANGE, 8'd0, 8'(TBL_SLOTS - 1), 16'h0000);
    tx_burst = 1'b0;
    drain_results();
  endtask

  // Mixed traffic in chunks with their own idling mode; the sender drains
  // every other chunk.
  task automatic test_random_traffic(int total);
    int         pick;
    logic [1:0] mode;
    cmd_t       c;
    logic [7:0] a;
    logic [7:0] b;
    for (int n = 0; n < total; n++) begin
      if (n % 40 == 0) begin
        if (n % 80 == 0 && n > 0) drain_results();
        mode     = 2'($urandom_range(0, 3));
        tx_burst = mode[0];
        rx_burst = mode[1];
      end
      pick = $urandom_range(0, 99);
      a    = pick_fd();
      b    = pick_fd();
      if (pick < 2) c = CMD_CLEAR;
      else if (pick < 10) c = CMD_LOWEST_FREE;
      else if (pick < 22) c = CMD_FREE;
      else if (pick < 37) c = CMD_GET;
      else if (pick < 62) c = CMD_INSTALL;
      else if (pick < 74) c = CMD_DUP;
      else if (pick < 88) c = CMD_DUP2;
      else begin
        c = CMD_CLOSE_RANGE;
        // Mostly short, well-ordered ranges.
        if (a < TBL_SLOTS && $urandom_range(0, 9) < 8) begin
          b = a + 8'($urandom_range(0, 5));
          if (b >= TBL_SLOTS) b = 8'(TBL_SLOTS - 1);
        end
      end
      send_req(c, a, b, pick_handle());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test flow
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    slot_busy  = '0;
    open_slots = 0;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.cmd       <= CMD_CLEAR;
    req_ch.fd_a      <= '0;
    req_ch.fd_b      <= '0;
    req_ch.handle_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_install_get();
    test_dup_paths();
    test_close_and_clear();
    test_full_table_backpressure();
    test_random_traffic(272);
    drain_results();

    // Room for any stray result after the last one owed.
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Sent %0d requests; checked %0d results (%0d close notices, %0d rejections).",
             reqs_sent, results_seen, notices_seen, rejects_seen);
    $display("Phases: directed corners, full table under a long hold-off, mixed traffic.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dst_pkg.sv
rtl/core/dst_req_if.sv
rtl/core/dst_res_if.sv
rtl/core/dst_ram.sv
rtl/core/dst_cursor.sv
rtl/core/descriptor_slot_table.sv
verif/descriptor_slot_table_tb.sv
